// ----- rtl/pktb_pkg.sv -----
// Shared types, widths and constants of the per-key token bucket limiter.
package pktb_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam logic [62:0] IDLE_EVICT_US = 63'd60000000;

    localparam int KEY_W   = 64;
    localparam int TOK_W   = 40;
    localparam int TIME_W  = 63;
    localparam int LIMIT_W = 7;
    localparam int BURST_W = 16;
    localparam int RATE_W  = 25;

    localparam logic [TOK_W-1:0] ONE_TOKEN = 40'h00_0100_0000;

    // Configuration register indexes
    localparam logic [1:0] CFG_TABLE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_BURST_SIZE  = 2'd1;
    localparam logic [1:0] CFG_REFILL_RATE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_RATE    = 2'd3;

    // One table entry as stored in memory
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TOK_W-1:0]  tokens;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    // Status returned by the refill unit
    typedef struct packed {
        logic             done;
        logic             idle;
        logic [TOK_W-1:0] level;
    } refill_res_t;

endpackage

// ----- rtl/pktb_table_ram.sv -----
// Bucket table memory: one write port, one registered read port.
module pktb_table_ram (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [pktb_pkg::IDX_W-1:0] wr_addr,
    input  pktb_pkg::entry_t           wr_data,
    input  logic                       rd_en,
    input  logic [pktb_pkg::IDX_W-1:0] rd_addr,
    output pktb_pkg::entry_t           rd_data
);
    import pktb_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/pktb_refill.sv -----
// Refill unit: elapsed time times rate over a shared 32x25 multiplier, clamped at ceiling.
module pktb_refill (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [pktb_pkg::TOK_W-1:0]    tokens,
    input  logic [pktb_pkg::TIME_W-1:0]   stamp,
    input  logic [pktb_pkg::TIME_W-1:0]   now,
    input  logic [pktb_pkg::RATE_W-1:0]   rate,
    input  logic [pktb_pkg::TOK_W-1:0]    cap,
    output pktb_pkg::refill_res_t         res
);
    import pktb_pkg::*;

    typedef enum logic [2:0] {R_IDLE, R_LO, R_HI, R_SUM, R_FIN} rstate_t;

    rstate_t           state_reg;
    logic [40:0]       esat_reg;
    logic              idle_reg;
    logic [TOK_W-1:0]  tok_reg;
    logic [TOK_W-1:0]  cap_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [56:0]       plo_reg;
    logic [56:0]       phi_reg;
    logic [TOK_W-1:0]  add_reg;
    logic [TOK_W-1:0]  level_reg;
    logic              done_reg;

    logic [TIME_W-1:0] elapsed;
    logic [40:0]       esat;
    logic [31:0]       mul_a;
    logic [56:0]       mul_p;
    logic [65:0]       prod;
    logic [40:0]       sum;

    // Elapsed time; anything at or above 2^40 us saturates any nonzero rate
    assign elapsed = (now >= stamp) ? now - stamp : '0;
    assign esat    = (|elapsed[TIME_W-1:40]) ? {1'b1, 40'b0} : {1'b0, elapsed[39:0]};

    // Shared multiplier: low word first, then high bits
    assign mul_a = (state_reg == R_HI) ? {23'b0, esat_reg[40:32]} : esat_reg[31:0];
    assign mul_p = 57'(mul_a) * 57'(rate_reg);

    assign prod = 66'(plo_reg) + {phi_reg[33:0], 32'b0};
    assign sum  = {1'b0, tok_reg} + {1'b0, add_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == R_FIN);
            case (state_reg)
                R_IDLE: begin
                    if (start) begin
                        esat_reg  <= esat;
                        idle_reg  <= (elapsed >= IDLE_EVICT_US);
                        tok_reg   <= tokens;
                        cap_reg   <= cap;
                        rate_reg  <= rate;
                        state_reg <= R_LO;
                    end
                end
                R_LO: begin
                    plo_reg   <= mul_p;
                    state_reg <= R_HI;
                end
                R_HI: begin
                    phi_reg   <= mul_p;
                    state_reg <= R_SUM;
                end
                R_SUM: begin
                    add_reg   <= (prod > 66'(cap_reg)) ? cap_reg : prod[TOK_W-1:0];
                    state_reg <= R_FIN;
                end
                R_FIN: begin
                    level_reg <= (sum < {1'b0, cap_reg}) ? sum[TOK_W-1:0] : cap_reg;
                    state_reg <= R_IDLE;
                end
                default: state_reg <= R_IDLE;
            endcase
        end
    end

    assign res.done  = done_reg;
    assign res.idle  = idle_reg;
    assign res.level = level_reg;

endmodule

// ----- rtl/per_key_token_bucket_limiter_core.sv -----
// Top level: request sequencer, bucket table and configuration registers.
//
// Requests enter on the s_ stream channel: origin_key, origin_ok and now_us
// packed in s_tdata. Each request yields exactly one result on the m_ channel
// with the admitted flag and a two-bit status. One request is handled at a
// time; s_tready is high only while the sequencer is idle.
// An invalid request is answered without a scan of the table. A known key is
// found by a linear scan of the table, one entry per cycle through the memory
// read port, then the refill unit brings its tokens up to date. A miss scans
// all 64 entries. When the table is at its limit, an eviction pass reads each
// entry and runs the refill unit on it. The shared multiplier in the refill
// unit and the single memory read port set the pace of these steps.
// The result sits in an output register; the next request is taken while it
// waits, and the sequencer holds a finished result until the output frees.
// Configuration writes on cfg_* are taken at any time (cfg_ready is high).
// Reset (aresetn low, synchronous) empties the table, clears the clock and
// restores table_limit 64, burst_size 10, refill_rate 16777.
module per_key_token_bucket_limiter_core (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: origin_key[63:0], origin_ok[64], now_us[127:65]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,
    // m_tdata: admitted[0], status[2:1], zero[7:3]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import pktb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_EV_RD, S_EV_ST, S_EV_WT, S_EV_END,
        S_NEW, S_REF_ST, S_REF_WT, S_RESP
    } state_t;

    state_t               state_reg;
    logic [LIMIT_W-1:0]   table_limit_reg;
    logic [BURST_W-1:0]   burst_size_reg;
    logic [RATE_W-1:0]    refill_rate_reg;
    logic [TIME_W-1:0]    latest_reg;
    logic [TABLE_DEPTH-1:0] used_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [IDX_W-1:0]     iss_idx_reg;
    logic                 iss_on_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic                 cmp_v_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     slot_reg;
    logic [TOK_W-1:0]     hold_tok_reg;
    logic [TIME_W-1:0]    hold_stamp_reg;
    logic                 res_adm_reg;
    logic [1:0]           res_st_reg;
    logic                 m_tvalid_reg;
    logic                 m_adm_reg;
    logic [1:0]           m_st_reg;

    logic [TOK_W-1:0]     cap;
    logic [CNT_W-1:0]     lim;
    logic                 s_acc;
    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    entry_t               ram_wr_data;
    logic                 ram_rd_en;
    logic [IDX_W-1:0]     ram_rd_addr;
    entry_t               ram_rd_data;
    logic                 rf_start;
    logic [TOK_W-1:0]     rf_tokens;
    logic [TIME_W-1:0]    rf_stamp;
    refill_res_t          rf_res;
    logic                 hit;
    logic                 evict;
    logic                 take;
    logic [TOK_W-1:0]     new_tok;

    assign cap   = {burst_size_reg, 24'b0};
    assign lim   = ({25'b0, table_limit_reg} > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                                 : CNT_W'(table_limit_reg);
    assign s_acc = s_tvalid && s_tready;

    // Memory read: search and eviction scans
    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = iss_idx_reg;
        if (state_reg == S_SEARCH && iss_on_reg) begin
            ram_rd_en = 1'b1;
        end else if (state_reg == S_EV_RD) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = slot_reg;
        end
    end

    // Token take after refill
    assign take    = (rf_res.level >= ONE_TOKEN);
    assign new_tok = take ? rf_res.level - ONE_TOKEN : rf_res.level;

    // Memory write: new bucket or updated bucket
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = slot_reg;
        ram_wr_data = '{key: key_reg, tokens: cap, stamp: now_reg};
        if (state_reg == S_NEW) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = free_idx_reg;
        end else if (state_reg == S_REF_WT && rf_res.done) begin
            ram_wr_en          = 1'b1;
            ram_wr_data.tokens = new_tok;
        end
    end

    // Refill unit operands
    assign rf_start  = (state_reg == S_EV_ST) || (state_reg == S_REF_ST);
    assign rf_tokens = (state_reg == S_EV_ST) ? ram_rd_data.tokens : hold_tok_reg;
    assign rf_stamp  = (state_reg == S_EV_ST) ? ram_rd_data.stamp : hold_stamp_reg;

    assign hit   = cmp_v_reg && used_reg[cmp_idx_reg] && (ram_rd_data.key == key_reg);
    assign evict = used_reg[slot_reg] && rf_res.idle && (rf_res.level >= cap);

    pktb_table_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    pktb_refill u_refill (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rf_start),
        .tokens  (rf_tokens),
        .stamp   (rf_stamp),
        .now     (now_reg),
        .rate    (refill_rate_reg),
        .cap     (cap),
        .res     (rf_res)
    );

    // Sequencer, table state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            table_limit_reg <= 7'd64;
            burst_size_reg  <= 16'd10;
            refill_rate_reg <= 25'd16777;
            latest_reg      <= '0;
            used_reg        <= '0;
            cnt_reg         <= '0;
            iss_on_reg      <= 1'b0;
            cmp_v_reg       <= 1'b0;
            free_found_reg  <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_TABLE_LIMIT: table_limit_reg <= cfg_data[LIMIT_W-1:0];
                    CFG_BURST_SIZE:  burst_size_reg  <= cfg_data[BURST_W-1:0];
                    CFG_REFILL_RATE: refill_rate_reg <= cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end

            // Output register: loaded from S_RESP, emptied by the receiver
            if (m_tready || state_reg == S_RESP) begin
                m_tvalid_reg <= (state_reg == S_RESP);
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        key_reg <= s_tdata[63:0];
                        now_reg <= s_tdata[127:65];
                        if (!s_tdata[64] || s_tdata[127:65] < latest_reg) begin
                            res_adm_reg <= 1'b0;
                            res_st_reg  <= ST_INVALID;
                            state_reg   <= S_RESP;
                        end else begin
                            latest_reg     <= s_tdata[127:65];
                            iss_idx_reg    <= '0;
                            iss_on_reg     <= 1'b1;
                            cmp_v_reg      <= 1'b0;
                            free_found_reg <= 1'b0;
                            state_reg      <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    // Issue side
                    cmp_v_reg   <= iss_on_reg;
                    cmp_idx_reg <= iss_idx_reg;
                    if (iss_on_reg) begin
                        iss_idx_reg <= iss_idx_reg + 1'b1;
                        if (iss_idx_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                            iss_on_reg <= 1'b0;
                        end
                    end
                    // Compare side
                    if (cmp_v_reg) begin
                        if (!used_reg[cmp_idx_reg] && !free_found_reg) begin
                            free_idx_reg   <= cmp_idx_reg;
                            free_found_reg <= 1'b1;
                        end
                        if (hit) begin
                            slot_reg       <= cmp_idx_reg;
                            hold_tok_reg   <= ram_rd_data.tokens;
                            hold_stamp_reg <= ram_rd_data.stamp;
                            state_reg      <= S_REF_ST;
                        end else if (cmp_idx_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                            if (cnt_reg >= lim) begin
                                slot_reg  <= '0;
                                state_reg <= S_EV_RD;
                            end else begin
                                state_reg <= S_NEW;
                            end
                        end
                    end
                end
                S_EV_RD: begin
                    // Free slot is searched again from the bottom during eviction
                    if (slot_reg == '0) begin
                        free_found_reg <= 1'b0;
                    end
                    state_reg <= S_EV_ST;
                end
                S_EV_ST: state_reg <= S_EV_WT;
                S_EV_WT: begin
                    if (rf_res.done) begin
                        if (evict) begin
                            used_reg[slot_reg] <= 1'b0;
                            cnt_reg            <= cnt_reg - 1'b1;
                        end
                        if ((!used_reg[slot_reg] || evict) && !free_found_reg) begin
                            free_idx_reg   <= slot_reg;
                            free_found_reg <= 1'b1;
                        end
                        if (slot_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                            state_reg <= S_EV_END;
                        end else begin
                            slot_reg  <= slot_reg + 1'b1;
                            state_reg <= S_EV_RD;
                        end
                    end
                end
                S_EV_END: begin
                    if (cnt_reg >= lim || !free_found_reg) begin
                        res_adm_reg <= 1'b0;
                        res_st_reg  <= ST_FULL;
                        state_reg   <= S_RESP;
                    end else begin
                        state_reg <= S_NEW;
                    end
                end
                S_NEW: begin
                    used_reg[free_idx_reg] <= 1'b1;
                    cnt_reg                <= cnt_reg + 1'b1;
                    slot_reg               <= free_idx_reg;
                    hold_tok_reg           <= cap;
                    hold_stamp_reg         <= now_reg;
                    state_reg              <= S_REF_ST;
                end
                S_REF_ST: state_reg <= S_REF_WT;
                S_REF_WT: begin
                    if (rf_res.done) begin
                        res_adm_reg <= take;
                        res_st_reg  <= take ? ST_OK : ST_RATE;
                        state_reg   <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_adm_reg <= res_adm_reg;
                        m_st_reg  <= res_st_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {5'b0, m_st_reg, m_adm_reg};

    // Checks
    a_cnt_matches_used: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == CNT_W'($countones(used_reg)))
        else $error("entry count out of step with used bits");

    a_admit_means_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == ST_OK)))
        else $error("admitted flag disagrees with status");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("request accepted while another is in work");

endmodule
